FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the seed residual RTL.
// Each macro expands to one labeled concurrent assertion on a clock and a reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: the consequent holds whenever the antecedent does.
`define ASSERT_IMP(name, clk_sig, rst_sig, ante, cons) \
  name: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication: the consequent holds in the cycle after the antecedent.
`define ASSERT_NXT(name, clk_sig, rst_sig, ante, cons) \
  name: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

FILE: hw/rtl/shlr_pkg.sv
// Shared widths and payload types for the seed hit line residual block.
// No dependencies; every module of the block uses this package.
`timescale 1ns / 1ps
`default_nettype none

package shlr_pkg;

  // Coordinate and result widths.
  localparam int COORD_WIDTH = 24;
  localparam int RES_WIDTH   = 48;

  // Differences of two coordinates, signed.
  localparam int DIFF_W = COORD_WIDTH + 1;
  // Signed product of two differences.
  localparam int PROD_W = 2 * COORD_WIDTH + 1;
  // Magnitude of the cross term and the squared chord length.
  localparam int MAG_W  = 2 * COORD_WIDTH + 1;
  // Square of the cross term.
  localparam int SQ_W   = 2 * MAG_W;
  // Quotient of the squared cross term by the squared chord length.
  localparam int QUO_W  = 2 * COORD_WIDTH + 1;
  // Integer square root of the quotient.
  localparam int ROOT_W = COORD_WIDTH + 1;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  typedef struct packed {
    coord_t inner_radius;
    coord_t inner_z;
    coord_t middle_radius;
    coord_t middle_z;
    coord_t outer_radius;
    coord_t outer_z;
  } seed_t;

  typedef struct packed {
    logic [RES_WIDTH-1:0] residual;
    logic                 degenerate;
  } result_t;

  // Request into the divider pipeline.
  typedef struct packed {
    logic [SQ_W-1:0]  dividend;
    logic [MAG_W-1:0] divisor;
    logic             square;
    logic             degenerate;
  } div_req_t;

  // Quotient out of the divider pipeline.
  typedef struct packed {
    logic [QUO_W-1:0] quotient;
    logic             square;
    logic             degenerate;
  } quo_t;

  // Quotient and its root out of the root pipeline.
  typedef struct packed {
    logic [QUO_W-1:0]  quotient;
    logic [ROOT_W-1:0] root;
    logic              square;
    logic              degenerate;
  } root_t;

endpackage

`default_nettype wire

FILE: hw/rtl/shlr_div.sv
// Pipelined restoring divider: one quotient bit per register stage.
// Depends on shlr_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module shlr_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  shlr_pkg::div_req_t req,
  output logic               quo_valid,
  input  logic               quo_stall,
  output shlr_pkg::quo_t     quo
);

  localparam int MAG_W = shlr_pkg::MAG_W;
  localparam int SQ_W  = shlr_pkg::SQ_W;
  localparam int QUO_W = shlr_pkg::QUO_W;
  localparam int LAST  = QUO_W - 1;

  // Stage registers. The shift register holds the dividend bits still to be
  // brought down at the top and the quotient bits found so far at the bottom.
  logic             vld [QUO_W];
  logic [MAG_W-1:0] rem [QUO_W];
  logic [QUO_W-1:0] sh  [QUO_W];
  logic [MAG_W-1:0] dvs [QUO_W];
  logic             sq  [QUO_W];
  logic             dg  [QUO_W];
  wire  [QUO_W-1:0] en;

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    logic             v_src;
    logic [MAG_W-1:0] rem_src;
    logic [QUO_W-1:0] sh_src;
    logic [MAG_W-1:0] dvs_src;
    logic             sq_src;
    logic             dg_src;
    logic [MAG_W:0]   trial;
    logic             fits;

    // The high dividend bits start as the partial remainder; they are below
    // the divisor because the quotient fits in QUO_W bits.
    if (k == 0) begin : g_first
      assign v_src   = req_valid;
      assign rem_src = req.dividend[SQ_W-1:QUO_W];
      assign sh_src  = req.dividend[QUO_W-1:0];
      assign dvs_src = req.divisor;
      assign sq_src  = req.square;
      assign dg_src  = req.degenerate;
    end else begin : g_next
      assign v_src   = vld[k-1];
      assign rem_src = rem[k-1];
      assign sh_src  = sh[k-1];
      assign dvs_src = dvs[k-1];
      assign sq_src  = sq[k-1];
      assign dg_src  = dg[k-1];
    end

    // A stage loads when it is empty or its content moves on.
    if (k == LAST) begin : g_en_last
      assign en[k] = !vld[k] || !quo_stall;
    end else begin : g_en_mid
      assign en[k] = !vld[k] || en[k+1];
    end

    // Bring down one dividend bit and try the subtraction.
    assign trial = {rem_src, sh_src[QUO_W-1]};
    assign fits  = trial >= {1'b0, dvs_src};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en[k]) begin
        vld[k] <= v_src;
      end
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        rem[k] <= fits ? MAG_W'(trial - {1'b0, dvs_src}) : MAG_W'(trial);
        sh[k]  <= {sh_src[QUO_W-2:0], fits};
        dvs[k] <= dvs_src;
        sq[k]  <= sq_src;
        dg[k]  <= dg_src;
      end
    end
  end

  // Handshake toward both neighbors.
  assign req_stall      = !en[0];
  assign quo_valid      = vld[LAST];
  assign quo.quotient   = sh[LAST];
  assign quo.square     = sq[LAST];
  assign quo.degenerate = dg[LAST];

  `ASSERT_IMP(a_rem_below_divisor, clk, rst, vld[LAST], rem[LAST] < dvs[LAST])
  `ASSERT_IMP(a_degenerate_quotient_zero, clk, rst, vld[LAST] && dg[LAST], sh[LAST] == '0)
  `ASSERT_NXT(a_held_head_stays, clk, rst, vld[0] && !en[0], vld[0])

endmodule

`default_nettype wire

FILE: hw/rtl/shlr_sqrt.sv
// Pipelined integer square root: one root bit per register stage.
// Depends on shlr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module shlr_sqrt (
  input  logic            clk,
  input  logic            rst,
  input  logic            quo_valid,
  output logic            quo_stall,
  input  shlr_pkg::quo_t  quo,
  output logic            root_valid,
  input  logic            root_stall,
  output shlr_pkg::root_t root
);

  localparam int QUO_W  = shlr_pkg::QUO_W;
  localparam int ROOT_W = shlr_pkg::ROOT_W;
  localparam int PAD_W  = 2 * ROOT_W;
  localparam int REM_W  = ROOT_W + 1;
  localparam int LAST   = ROOT_W - 1;

  logic              vld [ROOT_W];
  logic [QUO_W-1:0]  q   [ROOT_W];
  logic [ROOT_W-1:0] rt  [ROOT_W];
  logic [REM_W-1:0]  rem [ROOT_W];
  logic              sq  [ROOT_W];
  logic              dg  [ROOT_W];
  wire  [ROOT_W-1:0] en;

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    logic              v_src;
    logic [QUO_W-1:0]  q_src;
    logic [ROOT_W-1:0] rt_src;
    logic [REM_W-1:0]  rem_src;
    logic              sq_src;
    logic              dg_src;
    logic [PAD_W-1:0]  qpad;
    logic [REM_W+1:0]  trial;
    logic [REM_W+1:0]  cand;
    logic              fits;

    if (k == 0) begin : g_first
      assign v_src   = quo_valid;
      assign q_src   = quo.quotient;
      assign rt_src  = '0;
      assign rem_src = '0;
      assign sq_src  = quo.square;
      assign dg_src  = quo.degenerate;
    end else begin : g_next
      assign v_src   = vld[k-1];
      assign q_src   = q[k-1];
      assign rt_src  = rt[k-1];
      assign rem_src = rem[k-1];
      assign sq_src  = sq[k-1];
      assign dg_src  = dg[k-1];
    end

    if (k == LAST) begin : g_en_last
      assign en[k] = !vld[k] || !root_stall;
    end else begin : g_en_mid
      assign en[k] = !vld[k] || en[k+1];
    end

    // Bring down the next pair of quotient bits and try 4*root + 1.
    assign qpad  = PAD_W'(q_src);
    assign trial = {rem_src, qpad[PAD_W-1-2*k -: 2]};
    assign cand  = {1'b0, rt_src, 2'b01};
    assign fits  = trial >= cand;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en[k]) begin
        vld[k] <= v_src;
      end
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        q[k]   <= q_src;
        rt[k]  <= {rt_src[ROOT_W-2:0], fits};
        rem[k] <= fits ? REM_W'(trial - cand) : REM_W'(trial);
        sq[k]  <= sq_src;
        dg[k]  <= dg_src;
      end
    end
  end

  assign quo_stall       = !en[0];
  assign root_valid      = vld[LAST];
  assign root.quotient   = q[LAST];
  assign root.root       = rt[LAST];
  assign root.square     = sq[LAST];
  assign root.degenerate = dg[LAST];

endmodule

`default_nettype wire

FILE: hw/rtl/seed_hit_line_residual_top.sv
// Top level of the seed hit line residual block: front arithmetic, divider,
// root and output register. Depends on shlr_pkg, shlr_div, shlr_sqrt, assert_macros.svh.
// The block takes one seed per clock while seed_stall is low and returns one
// result per seed, in order. Stage 1 loads at the edge that accepts a seed, and
// the output register is the 81st register stage: 6 front stages, one divider
// stage per quotient bit (49), one root stage per root bit (25) and one output
// register. The divider and root stage chains hold most of these stages.
// square_mode picks floor(N*N/S), saturated at 2^48-1, over floor(|N|/sqrt(S)). It is
// taken per request as it enters. Outer hits with equal z give degenerate with residual 0.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module seed_hit_line_residual_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic              cfg_data,
  input  logic              seed_valid,
  output logic              seed_stall,
  input  shlr_pkg::seed_t   seed,
  output logic              result_valid,
  input  logic              result_stall,
  output shlr_pkg::result_t result
);

  localparam int W         = shlr_pkg::COORD_WIDTH;
  localparam int RES_WIDTH = shlr_pkg::RES_WIDTH;
  localparam int DIFF_W    = shlr_pkg::DIFF_W;
  localparam int PROD_W    = shlr_pkg::PROD_W;
  localparam int MAG_W     = shlr_pkg::MAG_W;
  localparam int SQ_W      = shlr_pkg::SQ_W;
  localparam int QUO_W     = shlr_pkg::QUO_W;
  localparam int ROOT_W    = shlr_pkg::ROOT_W;
  localparam int SQR_W     = 2 * W;
  localparam int HALF_W    = W + 1;
  localparam int HL_W      = 2 * W + 1;
  localparam int LL_W      = 2 * W + 2;

  // Mode register.
  logic square_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      square_mode <= 1'b0;
    end else if (cfg_write) begin
      square_mode <= cfg_data;
    end
  end

  // Stage valid bits and load enables.
  logic v1, v2, v3, v4, v5, v6;
  logic en1, en2, en3, en4, en5, en6, out_en;
  logic div_stall, quo_valid, quo_stall, rt_valid, rt_stall;

  assign out_en = !result_valid || !result_stall;
  assign en6    = !v6 || !div_stall;
  assign en5    = !v5 || en6;
  assign en4    = !v4 || en5;
  assign en3    = !v3 || en4;
  assign en2    = !v2 || en3;
  assign en1    = !v1 || en2;
  assign seed_stall = !en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else begin
      if (en1) v1 <= seed_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) v5 <= v4;
      if (en6) v6 <= v5;
    end
  end

  // Stage 1: coordinate differences.
  logic signed [DIFF_W-1:0] a1, b1, dr1, dz1;
  logic                     sq1;

  always_ff @(posedge clk) begin
    if (en1) begin
      a1  <= DIFF_W'(seed.middle_radius) - DIFF_W'(seed.outer_radius);
      b1  <= DIFF_W'(seed.middle_z) - DIFF_W'(seed.outer_z);
      dr1 <= DIFF_W'(seed.outer_radius) - DIFF_W'(seed.inner_radius);
      dz1 <= DIFF_W'(seed.outer_z) - DIFF_W'(seed.inner_z);
      sq1 <= square_mode;
    end
  end

  // Stage 2: cross products and squares.
  logic signed [PROD_W-1:0] p1_2, p2_2;
  logic [SQR_W-1:0]         zz2, rr2;
  logic                     sq2, dg2;

  always_ff @(posedge clk) begin
    if (en2) begin
      p1_2 <= PROD_W'(a1) * PROD_W'(dz1);
      p2_2 <= PROD_W'(dr1) * PROD_W'(b1);
      zz2  <= SQR_W'(PROD_W'(dz1) * PROD_W'(dz1));
      rr2  <= SQR_W'(PROD_W'(dr1) * PROD_W'(dr1));
      sq2  <= sq1;
      dg2  <= (dz1 == '0);
    end
  end

  // Stage 3: cross term N and squared chord S. A degenerate seed is
  // steered to N = 0, S = 1 so that the quotient is zero.
  logic signed [PROD_W:0] n3;
  logic [MAG_W-1:0]       s3;
  logic                   sq3, dg3;

  always_ff @(posedge clk) begin
    if (en3) begin
      if (dg2) begin
        n3 <= '0;
        s3 <= MAG_W'(1);
      end else begin
        n3 <= (PROD_W + 1)'(p1_2) - (PROD_W + 1)'(p2_2);
        s3 <= MAG_W'(zz2) + MAG_W'(rr2);
      end
      sq3 <= sq2;
      dg3 <= dg2;
    end
  end

  // Stage 4: magnitude of N.
  logic [MAG_W-1:0] nm4, s4;
  logic             sq4, dg4;

  always_ff @(posedge clk) begin
    if (en4) begin
      nm4 <= n3[PROD_W] ? MAG_W'(-n3) : MAG_W'(n3);
      s4  <= s3;
      sq4 <= sq3;
      dg4 <= dg3;
    end
  end

  // Stage 5: partial products of N squared, split into high and low halves.
  logic [W-1:0]      hi4;
  logic [HALF_W-1:0] lo4;
  logic [SQR_W-1:0]  hh5;
  logic [HL_W-1:0]   hl5;
  logic [LL_W-1:0]   ll5;
  logic [MAG_W-1:0]  s5;
  logic              sq5, dg5;

  assign hi4 = nm4[MAG_W-1:HALF_W];
  assign lo4 = nm4[HALF_W-1:0];

  always_ff @(posedge clk) begin
    if (en5) begin
      hh5 <= SQR_W'(hi4) * SQR_W'(hi4);
      hl5 <= HL_W'(hi4) * HL_W'(lo4);
      ll5 <= LL_W'(lo4) * LL_W'(lo4);
      s5  <= s4;
      sq5 <= sq4;
      dg5 <= dg4;
    end
  end

  // Stage 6: assemble N squared.
  shlr_pkg::div_req_t req6;

  always_ff @(posedge clk) begin
    if (en6) begin
      req6.dividend   <= (SQ_W'(hh5) << (2 * HALF_W)) + (SQ_W'(hl5) << (HALF_W + 1))
                         + SQ_W'(ll5);
      req6.divisor    <= s5;
      req6.square     <= sq5;
      req6.degenerate <= dg5;
    end
  end

  // Division and root pipelines.
  shlr_pkg::quo_t  quo;
  shlr_pkg::root_t rt;

  shlr_div u_div (
    .clk       (clk),
    .rst       (rst),
    .req_valid (v6),
    .req_stall (div_stall),
    .req       (req6),
    .quo_valid (quo_valid),
    .quo_stall (quo_stall),
    .quo       (quo)
  );

  shlr_sqrt u_sqrt (
    .clk        (clk),
    .rst        (rst),
    .quo_valid  (quo_valid),
    .quo_stall  (quo_stall),
    .quo        (quo),
    .root_valid (rt_valid),
    .root_stall (rt_stall),
    .root       (rt)
  );

  assign rt_stall = !out_en;

  // Saturated squared distance.
  logic [RES_WIDTH-1:0] sq_res;

  if (QUO_W > RES_WIDTH) begin : g_sat
    assign sq_res = (|rt.quotient[QUO_W-1:RES_WIDTH]) ? '1 : rt.quotient[RES_WIDTH-1:0];
  end else begin : g_nosat
    assign sq_res = RES_WIDTH'(rt.quotient);
  end

  // Result selection.
  logic [RES_WIDTH-1:0] res_next;

  always_comb begin
    priority if (rt.degenerate) begin
      res_next = '0;
    end else if (rt.square) begin
      res_next = sq_res;
    end else begin
      res_next = RES_WIDTH'(rt.root);
    end
  end

  // Output register.
  logic res_square;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_en) begin
      result_valid <= rt_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en) begin
      result.residual   <= res_next;
      result.degenerate <= rt.degenerate;
      res_square        <= rt.square;
    end
  end

  `ASSERT_IMP(a_degenerate_zero_residual, clk, rst, result_valid && result.degenerate, result.residual == '0)
  `ASSERT_IMP(a_empty_output_takes_seed, clk, rst, !result_valid, !seed_stall)
  `ASSERT_IMP(a_distance_fits_root, clk, rst, result_valid && !res_square, result.residual[RES_WIDTH-1:ROOT_W] == '0)

endmodule

`default_nettype wire

FILE: bench/tb_seed_hit_line_residual_top.sv
// Self-checking testbench for seed_hit_line_residual_top, with randomized idling on both sides.
// Depends on shlr_pkg and on the RTL of the block; an exact integer predictor gives the results.
`timescale 1ns / 1ps

module tb_seed_hit_line_residual_top;

  localparam bit MODE_DISTANCE = 1'b0;
  localparam bit MODE_SQUARED  = 1'b1;
  localparam int DRAIN_CYCLES  = 120;

  logic              clk;
  logic              rst;
  logic              cfg_write;
  logic              cfg_data;
  logic              seed_valid;
  logic              seed_stall;
  shlr_pkg::seed_t   seed;
  logic              result_valid;
  logic              result_stall;
  shlr_pkg::result_t result;

  shlr_pkg::seed_t   pending_seeds[$];
  shlr_pkg::result_t expected_results[$];
  bit      square_mode_model;
  bit      seed_taken;
  bit      no_idle;
  bit      hold_start;
  int      hold_count;
  int      mismatches;

  seed_hit_line_residual_top DUT (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_data(cfg_data),
    .seed_valid(seed_valid), .seed_stall(seed_stall), .seed(seed),
    .result_valid(result_valid), .result_stall(result_stall), .result(result)
  );

  // Exact residual of the middle hit from the chord through the outer hits.
  function automatic shlr_pkg::result_t chord_residual(shlr_pkg::seed_t s, bit squared);
    longint a, b, dr, dz, n, chord_sq;
    logic [63:0] n_mag;
    logic [199:0] n_sq, trial;
    logic [47:0] d, cand;
    shlr_pkg::result_t r;
    a  = longint'($signed(s.middle_radius)) - longint'($signed(s.outer_radius));
    b  = longint'($signed(s.middle_z)) - longint'($signed(s.outer_z));
    dr = longint'($signed(s.outer_radius)) - longint'($signed(s.inner_radius));
    dz = longint'($signed(s.outer_z)) - longint'($signed(s.inner_z));
    r.residual = '0;
    r.degenerate = 1'b0;
    if (dz == 0) begin
      r.degenerate = 1'b1;
      return r;
    end
    n = a * dz - dr * b;
    n_mag = (n < 0) ? -n : n;
    n_sq = 200'(n_mag) * 200'(n_mag);
    chord_sq = dz * dz + dr * dr;
    // Largest value up to the saturation limit that still fits under N squared.
    d = '0;
    for (int bit_i = 47; bit_i >= 0; bit_i--) begin
      cand = d | (48'd1 << bit_i);
      trial = 200'(cand);
      if (!squared) trial = trial * trial;
      trial = trial * 200'(chord_sq);
      if (trial <= n_sq) d = cand;
    end
    r.residual = d;
    return r;
  endfunction

  function automatic shlr_pkg::coord_t random_coord();
    int kind;
    kind = $urandom_range(0, 9);
    if (kind < 4) return shlr_pkg::coord_t'($urandom);
    if (kind < 8) return shlr_pkg::coord_t'(int'($urandom_range(0, 4000)) - 2000);
    if (kind == 8) return shlr_pkg::coord_t'(24'h7FFFFF - $urandom_range(0, 15));
    return shlr_pkg::coord_t'(24'h800000 + $urandom_range(0, 15));
  endfunction

  function automatic shlr_pkg::seed_t random_seed();
    shlr_pkg::seed_t s;
    s.inner_radius  = random_coord();
    s.inner_z       = random_coord();
    s.middle_radius = random_coord();
    s.middle_z      = random_coord();
    s.outer_radius  = random_coord();
    s.outer_z       = random_coord();
    // Now and then the outer hits share z, which marks the seed degenerate.
    if ($urandom_range(0, 19) == 0) s.outer_z = s.inner_z;
    return s;
  endfunction

  function automatic shlr_pkg::seed_t make_seed(int r0, int z0, int r1, int z1,
                                                int r2, int z2);
    shlr_pkg::seed_t s;
    s.inner_radius = shlr_pkg::coord_t'(r0);  s.inner_z = shlr_pkg::coord_t'(z0);
    s.middle_radius = shlr_pkg::coord_t'(r1); s.middle_z = shlr_pkg::coord_t'(z1);
    s.outer_radius = shlr_pkg::coord_t'(r2);  s.outer_z = shlr_pkg::coord_t'(z2);
    return s;
  endfunction

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Request driver: offers queued seeds, idles at random, holds a stalled request.
  always @(negedge clk) begin
    if (rst) begin
      seed_valid <= 1'b0;
    end else if (seed_valid && !seed_taken) begin
      seed_valid <= 1'b1;
    end else if (pending_seeds.size() > 0 && (no_idle || $urandom_range(0, 99) >= 17)) begin
      seed <= pending_seeds.pop_front();
      seed_valid <= 1'b1;
    end else begin
      seed_valid <= 1'b0;
    end
  end

  // Receiver: random stalls, plus one long hold-off counted here.
  always @(negedge clk) begin
    if (hold_start) begin
      hold_start = 1'b0;
      hold_count = 400;
    end
    if (hold_count > 0) begin
      hold_count--;
      result_stall <= 1'b1;
    end else begin
      result_stall <= !no_idle && ($urandom_range(0, 99) < 17);
    end
  end

  // Monitor: tracks the mode, predicts accepted requests, checks results.
  always @(posedge clk) begin
    shlr_pkg::result_t exp_r;
    seed_taken = seed_valid && !seed_stall && !rst;
    if (!rst && cfg_write) square_mode_model = cfg_data;
    if (seed_taken) expected_results.push_back(chord_residual(seed, square_mode_model));
    if (!rst && result_valid && !result_stall) begin
      if (expected_results.size() == 0) begin
        $error("result with no request outstanding: residual %0d degenerate %0d",
               result.residual, result.degenerate);
        mismatches++;
      end else begin
        exp_r = expected_results.pop_front();
        if (result.residual !== exp_r.residual) begin
          $error("residual: expected %0d, actual %0d", exp_r.residual, result.residual);
          mismatches++;
        end
        if (result.degenerate !== exp_r.degenerate) begin
          $error("degenerate: expected %0d, actual %0d", exp_r.degenerate, result.degenerate);
          mismatches++;
        end
      end
    end
  end

  task automatic wait_drained();
    while (pending_seeds.size() > 0 || seed_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(bit m);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= m;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic queue_random(int count);
    repeat (count) pending_seeds.push_back(random_seed());
  endtask

  // Directed seeds: extremes, degenerate chords, collinear hits.
  task automatic queue_directed();
    pending_seeds.push_back(make_seed(0, 0, 0, 0, 0, 0));
    pending_seeds.push_back(make_seed(0, 0, 100, 0, 200, 0));
    pending_seeds.push_back(make_seed(-8388608, 5, 8388607, -3, 77, 5));
    pending_seeds.push_back(make_seed(0, 0, 256, 256, 512, 512));
    pending_seeds.push_back(make_seed(0, 0, 512, 0, 0, 256));
    pending_seeds.push_back(make_seed(0, -256, 256, 0, 0, 256));
    pending_seeds.push_back(make_seed(1, 1, 2, 5, 3, 2));
    pending_seeds.push_back(make_seed(0, -8388608, 8388607, 0, 0, 8388607));
    pending_seeds.push_back(make_seed(0, -8388608, -8388608, 0, 0, 8388607));
    pending_seeds.push_back(make_seed(-8388608, -8388608, 8388607, 8388607,
                                      -8388608, 8388607));
    pending_seeds.push_back(make_seed(8388607, 8388607, -8388608, -8388608,
                                      8388607, -8388607));
    pending_seeds.push_back(make_seed(-8388608, 0, 8388607, -8388608, 8388607, 1));
    pending_seeds.push_back(make_seed(0, 0, 8388607, 8388607, 0, 1));
    pending_seeds.push_back(make_seed(0, 0, -8388608, -8388608, 1, 1));
    pending_seeds.push_back(make_seed(-1, -1, -1, -1, -1, 0));
    pending_seeds.push_back(make_seed(8388607, -8388608, 8388607, 8388607,
                                      -8388608, 8388607));
    pending_seeds.push_back(make_seed(3, 4, 3, 4, 7, 9));
    pending_seeds.push_back(make_seed(5, 0, 9, 9, 5, 1));
  endtask

  // Stimulus sequence and end of run.
  initial begin
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_data = 1'b0;
    seed_valid = 1'b0;
    seed = '0;
    result_stall = 1'b0;
    square_mode_model = MODE_DISTANCE;
    no_idle = 1'b0;
    hold_start = 1'b0;
    hold_count = 0;
    mismatches = 0;
    repeat (8) @(negedge clk);
    rst = 1'b0;

    // Distance mode at reset value, directed seeds.
    queue_directed();
    wait_drained();

    // Squared mode, directed seeds again, then random with the sender pausing midway.
    write_mode(MODE_SQUARED);
    queue_directed();
    queue_random(160);
    wait_drained();
    queue_random(160);
    wait_drained();

    // Distance mode while the receiver holds off for a long stretch.
    write_mode(MODE_DISTANCE);
    hold_start = 1'b1;
    queue_random(340);
    wait_drained();

    // Squared mode with no idling on either side.
    write_mode(MODE_SQUARED);
    no_idle = 1'b1;
    queue_random(340);
    wait_drained();
    no_idle = 1'b0;

    // Back to distance mode with random idling.
    write_mode(MODE_DISTANCE);
    queue_random(330);
    wait_drained();

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #10_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
